// ===== src/fly_camera_orientation_update_top_macros.svh =====
// Assertion macros for the fly camera orientation update block.
// Included by the controller and the datapath; expects clk_i and rst_ni in scope.
`ifndef FLY_CAMERA_ORIENTATION_UPDATE_TOP_MACROS_SVH
`define FLY_CAMERA_ORIENTATION_UPDATE_TOP_MACROS_SVH

// Property that must hold at every clock edge out of reset
`define FCOU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define FCOU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/fcou_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the fly camera block.
// No dependencies.
package fcou_pkg;

  // Parameter defaults
  localparam int AngleBitsDef     = 24;
  localparam int VectorFracBitsDef = 14;

  // Register reset values
  localparam logic [15:0] MOVE_SPEED_RST  = 16'd13107;
  localparam logic [15:0] LOOK_GAIN_RST   = 16'd4660;
  localparam logic [22:0] PITCH_LIMIT_RST = 23'd4147701;

  // Configuration register indices
  localparam int          CFG_IDX_W       = 2;
  localparam int          CFG_DATA_W      = 23;
  localparam logic [1:0]  CFG_MOVE_SPEED  = 2'd0;
  localparam logic [1:0]  CFG_LOOK_GAIN   = 2'd1;
  localparam logic [1:0]  CFG_PITCH_LIMIT = 2'd2;

  // Position reset, Q16.16
  localparam logic signed [31:0] POS_X_RST = 32'sd0;
  localparam logic signed [31:0] POS_Y_RST = 32'sd458752;
  localparam logic signed [31:0] POS_Z_RST = 32'sd1310720;

  // CORDIC: 2^-32 turn angles, Q30 magnitudes
  localparam int                 CORDIC_STEPS = 30;
  localparam int                 CNT_W        = 5;
  localparam int                 CORDIC_XW    = 34;
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
  localparam logic [CNT_W-1:0]   MOVE_LAST    = 5'd3;
  localparam logic [CNT_W-1:0]   PROJ_LAST    = 5'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic             capture;
    logic             move;
    logic             angle;
    logic             rotate;
    logic             project;
    logic             load_out;
    logic [CNT_W-1:0] cnt;
  } fcou_cmd_t;

  // arctan(2^-i) in 2^-32 turn
  function automatic logic [31:0] cordic_atan(input logic [CNT_W-1:0] i);
    logic [31:0] r;
    case (i)
      5'd0:    r = 32'd536870912;
      5'd1:    r = 32'd316933406;
      5'd2:    r = 32'd167458907;
      5'd3:    r = 32'd85004756;
      5'd4:    r = 32'd42667331;
      5'd5:    r = 32'd21354465;
      5'd6:    r = 32'd10679838;
      5'd7:    r = 32'd5340245;
      5'd8:    r = 32'd2670163;
      5'd9:    r = 32'd1335087;
      5'd10:   r = 32'd667544;
      5'd11:   r = 32'd333772;
      5'd12:   r = 32'd166886;
      5'd13:   r = 32'd83443;
      5'd14:   r = 32'd41722;
      5'd15:   r = 32'd20861;
      5'd16:   r = 32'd10430;
      5'd17:   r = 32'd5215;
      5'd18:   r = 32'd2608;
      5'd19:   r = 32'd1304;
      5'd20:   r = 32'd652;
      5'd21:   r = 32'd326;
      5'd22:   r = 32'd163;
      5'd23:   r = 32'd81;
      5'd24:   r = 32'd41;
      5'd25:   r = 32'd20;
      5'd26:   r = 32'd10;
      5'd27:   r = 32'd5;
      5'd28:   r = 32'd3;
      5'd29:   r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/fcou_cordic.sv =====
// Iterative CORDIC rotator: cosine and sine of a 2^-32 turn angle, one step per cycle while step_i is high.
// Depends on fcou_pkg.
module fcou_cordic (
  input  logic                                    clk_i,
  input  logic                                    load_i,
  input  logic                                    step_i,
  input  logic [fcou_pkg::CNT_W-1:0]              idx_i,
  input  logic [31:0]                             angle_i,
  output logic signed [fcou_pkg::CORDIC_XW-1:0]   cos_o,
  output logic signed [fcou_pkg::CORDIC_XW-1:0]   sin_o
);

  localparam int XW = fcou_pkg::CORDIC_XW;
  localparam logic signed [32:0] QTR  = 33'sd1073741824;
  localparam logic signed [32:0] HALF = 33'sd2147483648;

  logic signed [XW-1:0] x_q, y_q, x_d, y_d;
  logic signed [32:0]   z_q, z_d, z_in, at;
  logic                 flip_q, flip_d;

  assign z_in = 33'($signed(angle_i));
  assign at   = 33'(fcou_pkg::cordic_atan(idx_i));

  // Fold into the right half-plane on load, then one micro-rotation per step
  always_comb begin
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    flip_d = flip_q;
    if (load_i) begin
      x_d = fcou_pkg::CORDIC_GAIN;
      y_d = '0;
      if (z_in > QTR) begin
        z_d    = z_in - HALF;
        flip_d = 1'b1;
      end else if (z_in < -QTR) begin
        z_d    = z_in + HALF;
        flip_d = 1'b1;
      end else begin
        z_d    = z_in;
        flip_d = 1'b0;
      end
    end else if (step_i) begin
      if (!z_q[32]) begin
        x_d = x_q - (y_q >>> idx_i);
        y_d = y_q + (x_q >>> idx_i);
        z_d = z_q - at;
      end else begin
        x_d = x_q + (y_q >>> idx_i);
        y_d = y_q - (x_q >>> idx_i);
        z_d = z_q + at;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    flip_q <= flip_d;
  end

  assign cos_o = flip_q ? -x_q : x_q;
  assign sin_o = flip_q ? -y_q : y_q;

endmodule

// ===== src/fcou_ctrl.sv =====
// Sequencer for the fly camera update: input transfer, movement, angles, rotation,
// projection and output hand-off. Depends on fcou_pkg and the assertion macros.
`include "fly_camera_orientation_update_top_macros.svh"
module fcou_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output fcou_pkg::fcou_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_MOVE    = 6'b000010,
    ST_ANGLE   = 6'b000100,
    ST_ROTATE  = 6'b001000,
    ST_PROJECT = 6'b010000,
    ST_FINISH  = 6'b100000
  } fcou_state_e;

  localparam logic [fcou_pkg::CNT_W-1:0] ROT_LAST =
    fcou_pkg::CNT_W'(fcou_pkg::CORDIC_STEPS);

  fcou_state_e                  state_q, state_d;
  logic [fcou_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic                         out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    cmd_o.cnt  = cnt_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_MOVE;
          cnt_d         = '0;
        end
      end
      ST_MOVE: begin
        cmd_o.move = 1'b1;
        if (cnt_q == fcou_pkg::MOVE_LAST) begin
          state_d = ST_ANGLE;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ANGLE: begin
        cmd_o.angle = 1'b1;
        state_d     = ST_ROTATE;
        cnt_d       = '0;
      end
      ST_ROTATE: begin
        cmd_o.rotate = 1'b1;
        if (cnt_q == ROT_LAST) begin
          state_d = ST_PROJECT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_PROJECT: begin
        cmd_o.project = 1'b1;
        if (cnt_q == fcou_pkg::PROJ_LAST) begin
          state_d = ST_FINISH;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Output slot: filled on load, emptied by a transfer
  assign out_valid_d = cmd_o.load_out | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  `FCOU_ASSERT(a_load_slot_free, cmd_o.load_out |-> (!out_valid_q || out_ready_i), "result loaded over a pending one")
  `FCOU_ASSERT(a_out_drop_on_transfer, $fell(out_valid_q) |-> $past(out_ready_i), "result dropped without transfer")
  `FCOU_ASSERT_NEXT(a_rotate_length, (state_q == ST_ROTATE) && (cnt_q != ROT_LAST), state_q == ST_ROTATE, "rotation cut short")

endmodule

// ===== src/fcou_datapath.sv =====
// Datapath: configuration, position, angles, two CORDIC units and the vector products.
// Depends on fcou_pkg, fcou_cordic and the assertion macros.
`include "fly_camera_orientation_update_top_macros.svh"
module fcou_datapath #(
  parameter int ANGLE_BITS       = fcou_pkg::AngleBitsDef,
  parameter int VECTOR_FRAC_BITS = fcou_pkg::VectorFracBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  fcou_pkg::fcou_cmd_t                cmd_i,
  input  logic                               cfg_we_i,
  input  logic [fcou_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [fcou_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                               look_enable_i,
  input  logic                               key_forward_i,
  input  logic                               key_backward_i,
  input  logic                               key_left_i,
  input  logic                               key_right_i,
  input  logic signed [15:0]                 mouse_dx_i,
  input  logic signed [15:0]                 mouse_dy_i,
  output logic signed [31:0]                 pos_x_o,
  output logic signed [31:0]                 pos_y_o,
  output logic signed [31:0]                 pos_z_o,
  output logic signed [15:0]                 front_x_o,
  output logic signed [15:0]                 front_y_o,
  output logic signed [15:0]                 front_z_o,
  output logic signed [15:0]                 right_x_o,
  output logic signed [15:0]                 right_y_o,
  output logic signed [15:0]                 right_z_o,
  output logic signed [15:0]                 up_x_o,
  output logic signed [15:0]                 up_y_o,
  output logic signed [15:0]                 up_z_o
);

  localparam int AB  = ANGLE_BITS;
  localparam int VFB = VECTOR_FRAC_BITS;
  localparam int VW  = VFB + 2;                 // vector component width
  localparam int EW  = (VW > 16) ? VW : 16;
  localparam int MW  = VW + 1 + 17;             // movement product width
  localparam int PW  = AB + 35;                 // pitch sum width
  localparam int XW  = fcou_pkg::CORDIC_XW;
  localparam int RW  = 2 * XW;                  // projection product width
  localparam int Q30_SH = 30 - VFB;
  localparam int Q60_SH = 60 - VFB;

  localparam logic signed [VW-1:0] ONE      = VW'(1) <<< VFB;
  localparam logic signed [MW-1:0] MOVE_RND = MW'(1) <<< (VFB - 1);
  localparam logic signed [RW-1:0] Q60_RND  = RW'(1) <<< (Q60_SH - 1);
  localparam logic signed [RW-1:0] Q30_RND  = (Q30_SH > 0) ? (RW'(1) <<< (Q30_SH - 1)) : '0;
  localparam logic signed [RW-1:0] ONE_W    = RW'(1) <<< VFB;
  localparam logic signed [AB-1:0] QUARTER  = AB'(1) <<< (AB - 2);
  localparam logic [AB-1:0]        YAW_RST  = AB'(3) << (AB - 2);
  localparam logic signed [33:0]   POS_MAX  = 34'sd2147483647;
  localparam logic signed [33:0]   POS_MIN  = -34'sd2147483648;

  // Round half up by SH bits and clamp to +/- one
  function automatic logic signed [VW-1:0] to_vec(input logic signed [RW-1:0] v,
                                                  input logic signed [RW-1:0] rnd,
                                                  input int sh);
    logic signed [RW-1:0] r;
    r = (v + rnd) >>> sh;
    if (r > ONE_W)       return ONE;
    else if (r < -ONE_W) return -ONE;
    else                 return VW'(r);
  endfunction

  function automatic logic signed [15:0] to_port(input logic signed [VW-1:0] v);
    logic signed [EW-1:0] e;
    e = EW'(v);
    return e[15:0];
  endfunction

  // Configuration registers
  logic [15:0] move_speed_q, look_gain_q;
  logic [22:0] pitch_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_speed_q  <= fcou_pkg::MOVE_SPEED_RST;
      look_gain_q   <= fcou_pkg::LOOK_GAIN_RST;
      pitch_limit_q <= fcou_pkg::PITCH_LIMIT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        fcou_pkg::CFG_MOVE_SPEED:  move_speed_q  <= cfg_data_i[15:0];
        fcou_pkg::CFG_LOOK_GAIN:   look_gain_q   <= cfg_data_i[15:0];
        fcou_pkg::CFG_PITCH_LIMIT: pitch_limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured item: key directions after cancelling, scaled mouse deltas
  logic               fw_pos_q, fw_neg_q, rt_pos_q, rt_neg_q;
  logic signed [32:0] dxg_q, dyg_q;
  logic signed [32:0] gain_s, dxg, dyg;

  assign gain_s = 33'($signed({1'b0, look_gain_q}));
  assign dxg    = 33'(mouse_dx_i) * gain_s;
  assign dyg    = 33'(mouse_dy_i) * gain_s;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      fw_pos_q <= look_enable_i & key_forward_i & ~key_backward_i;
      fw_neg_q <= look_enable_i & key_backward_i & ~key_forward_i;
      rt_pos_q <= look_enable_i & key_right_i & ~key_left_i;
      rt_neg_q <= look_enable_i & key_left_i & ~key_right_i;
      dxg_q    <= look_enable_i ? dxg : '0;
      dyg_q    <= look_enable_i ? dyg : '0;
    end
  end

  // Orientation state
  logic signed [31:0]   pos_q [3];
  logic [AB-1:0]        yaw_q;
  logic signed [AB-1:0] pitch_q;
  logic signed [VW-1:0] front_q [3];
  logic signed [VW-1:0] right_q [3];
  logic signed [VW-1:0] up_x_q, up_y_q, up_z_q;

  // Movement: product for axis cnt, position update for axis cnt-1
  logic signed [VW-1:0] fsel, rsel, fterm, rterm;
  logic signed [VW:0]   msum;
  logic signed [MW-1:0] mprod, move_prod_q, delta;
  logic signed [31:0]   psel;
  logic signed [33:0]   padd;
  logic signed [31:0]   pnew;

  always_comb begin
    case (cmd_i.cnt[1:0])
      2'd0:    begin fsel = front_q[0]; rsel = right_q[0]; end
      2'd1:    begin fsel = front_q[1]; rsel = right_q[1]; end
      default: begin fsel = front_q[2]; rsel = right_q[2]; end
    endcase
    fterm = fw_pos_q ? fsel : (fw_neg_q ? -fsel : '0);
    rterm = rt_pos_q ? rsel : (rt_neg_q ? -rsel : '0);
    msum  = (VW+1)'(fterm) + (VW+1)'(rterm);
    mprod = MW'(msum) * MW'($signed({1'b0, move_speed_q}));
  end

  always_comb begin
    delta = (move_prod_q + MOVE_RND) >>> VFB;
    case (cmd_i.cnt[1:0])
      2'd1:    psel = pos_q[0];
      2'd2:    psel = pos_q[1];
      default: psel = pos_q[2];
    endcase
    padd = 34'(psel) + 34'(delta);
    if (padd > POS_MAX)      pnew = 32'(POS_MAX);
    else if (padd < POS_MIN) pnew = 32'(POS_MIN);
    else                     pnew = 32'(padd);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.move && (cmd_i.cnt != fcou_pkg::MOVE_LAST)) move_prod_q <= mprod;
  end

  // Angle update: yaw wraps, pitch clamps to the effective limit
  logic signed [PW-1:0] psum, plim, pclamp;

  always_comb begin
    psum = PW'(pitch_q) + PW'(dyg_q);
    plim = (PW'(pitch_limit_q) > PW'(QUARTER)) ? PW'(QUARTER) : PW'(pitch_limit_q);
    if (psum > plim)       pclamp = plim;
    else if (psum < -plim) pclamp = -plim;
    else                   pclamp = psum;
  end

  // Sine and cosine of yaw and pitch in parallel
  logic [31:0]              ang_y, ang_p;
  logic signed [XW-1:0]     cy, sy, cp, sp;
  logic                     rot_load, rot_step;
  logic [fcou_pkg::CNT_W-1:0] rot_idx;

  assign ang_y    = 32'(yaw_q) << (32 - AB);
  assign ang_p    = 32'($unsigned(pitch_q)) << (32 - AB);
  assign rot_load = cmd_i.rotate && (cmd_i.cnt == '0);
  assign rot_step = cmd_i.rotate && (cmd_i.cnt != '0);
  assign rot_idx  = cmd_i.cnt - 1'b1;

  fcou_cordic u_cordic_yaw (
    .clk_i   (clk_i),
    .load_i  (rot_load),
    .step_i  (rot_step),
    .idx_i   (rot_idx),
    .angle_i (ang_y),
    .cos_o   (cy),
    .sin_o   (sy)
  );

  fcou_cordic u_cordic_pitch (
    .clk_i   (clk_i),
    .load_i  (rot_load),
    .step_i  (rot_step),
    .idx_i   (rot_idx),
    .angle_i (ang_p),
    .cos_o   (cp),
    .sin_o   (sp)
  );

  // Projection: one Q30 x Q30 product per cycle, rounded the cycle after
  logic signed [XW-1:0] opa, opb;
  logic signed [RW-1:0] rprod, proj_prod_q, proj_neg;
  logic signed [VW-1:0] proj_vec, proj_vec_neg;

  always_comb begin
    case (cmd_i.cnt[1:0])
      2'd0:    begin opa = cy; opb = cp; end
      2'd1:    begin opa = sy; opb = cp; end
      2'd2:    begin opa = cy; opb = sp; end
      default: begin opa = sy; opb = sp; end
    endcase
    rprod        = RW'(opa) * RW'(opb);
    proj_neg     = -proj_prod_q;
    proj_vec     = to_vec(proj_prod_q, Q60_RND, Q60_SH);
    proj_vec_neg = to_vec(proj_neg, Q60_RND, Q60_SH);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.project && (cmd_i.cnt != fcou_pkg::PROJ_LAST)) proj_prod_q <= rprod;
  end

  // State updates
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q[0]   <= fcou_pkg::POS_X_RST;
      pos_q[1]   <= fcou_pkg::POS_Y_RST;
      pos_q[2]   <= fcou_pkg::POS_Z_RST;
      yaw_q      <= YAW_RST;
      pitch_q    <= '0;
      front_q[0] <= '0;
      front_q[1] <= '0;
      front_q[2] <= -ONE;
      right_q[0] <= ONE;
      right_q[1] <= '0;
      right_q[2] <= '0;
    end else begin
      if (cmd_i.move) begin
        case (cmd_i.cnt[1:0])
          2'd1:    pos_q[0] <= pnew;
          2'd2:    pos_q[1] <= pnew;
          2'd3:    pos_q[2] <= pnew;
          default: ;
        endcase
      end
      if (cmd_i.angle) begin
        yaw_q   <= yaw_q + AB'(dxg_q);
        pitch_q <= AB'(pclamp);
      end
      if (cmd_i.project) begin
        case (cmd_i.cnt[2:0])
          3'd1: front_q[0] <= proj_vec;
          3'd2: front_q[2] <= proj_vec;
          3'd4: begin
            front_q[1] <= to_vec(RW'(sp), Q30_RND, Q30_SH);
            right_q[0] <= to_vec(RW'(-sy), Q30_RND, Q30_SH);
            right_q[2] <= to_vec(RW'(cy), Q30_RND, Q30_SH);
          end
          default: ;
        endcase
      end
    end
  end

  // Up vector, rebuilt every item
  always_ff @(posedge clk_i) begin
    if (cmd_i.project) begin
      case (cmd_i.cnt[2:0])
        3'd3: up_x_q <= proj_vec_neg;
        3'd4: begin
          up_z_q <= proj_vec_neg;
          up_y_q <= to_vec(RW'(cp), Q30_RND, Q30_SH);
        end
        default: ;
      endcase
    end
  end

  // Output registers
  logic signed [31:0] out_pos_q [3];
  logic signed [15:0] out_vec_q [9];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_pos_q[0] <= pos_q[0];
      out_pos_q[1] <= pos_q[1];
      out_pos_q[2] <= pos_q[2];
      out_vec_q[0] <= to_port(front_q[0]);
      out_vec_q[1] <= to_port(front_q[1]);
      out_vec_q[2] <= to_port(front_q[2]);
      out_vec_q[3] <= to_port(right_q[0]);
      out_vec_q[4] <= to_port(right_q[1]);
      out_vec_q[5] <= to_port(right_q[2]);
      out_vec_q[6] <= to_port(up_x_q);
      out_vec_q[7] <= to_port(up_y_q);
      out_vec_q[8] <= to_port(up_z_q);
    end
  end

  assign pos_x_o   = out_pos_q[0];
  assign pos_y_o   = out_pos_q[1];
  assign pos_z_o   = out_pos_q[2];
  assign front_x_o = out_vec_q[0];
  assign front_y_o = out_vec_q[1];
  assign front_z_o = out_vec_q[2];
  assign right_x_o = out_vec_q[3];
  assign right_y_o = out_vec_q[4];
  assign right_z_o = out_vec_q[5];
  assign up_x_o    = out_vec_q[6];
  assign up_y_o    = out_vec_q[7];
  assign up_z_o    = out_vec_q[8];

  `FCOU_ASSERT(a_pitch_in_range, (pitch_q <= QUARTER) && (pitch_q >= -QUARTER), "pitch beyond a quarter turn")

endmodule

// ===== src/fly_camera_orientation_update_top.sv =====
// Fly camera orientation update: one result per accepted item.
// Items pass through the move, angle, CORDIC, projection and hand-off
// states in order; a new item is accepted only once the last is loaded for
// output. Yaw and pitch run in parallel, each in its own 30-step CORDIC.
// Reset (async, active low) restores registers, position, angles, front and right vectors.
// Depends on fcou_pkg, fcou_ctrl, fcou_datapath.
module fly_camera_orientation_update_top #(
  parameter int ANGLE_BITS       = fcou_pkg::AngleBitsDef,
  parameter int VECTOR_FRAC_BITS = fcou_pkg::VectorFracBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [fcou_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [fcou_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            look_enable_i,
  input  logic                            key_forward_i,
  input  logic                            key_backward_i,
  input  logic                            key_left_i,
  input  logic                            key_right_i,
  input  logic signed [15:0]              mouse_dx_i,
  input  logic signed [15:0]              mouse_dy_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic signed [31:0]              pos_x_o,
  output logic signed [31:0]              pos_y_o,
  output logic signed [31:0]              pos_z_o,
  output logic signed [15:0]              front_x_o,
  output logic signed [15:0]              front_y_o,
  output logic signed [15:0]              front_z_o,
  output logic signed [15:0]              right_x_o,
  output logic signed [15:0]              right_y_o,
  output logic signed [15:0]              right_z_o,
  output logic signed [15:0]              up_x_o,
  output logic signed [15:0]              up_y_o,
  output logic signed [15:0]              up_z_o
);

  fcou_pkg::fcou_cmd_t cmd;

  fcou_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  fcou_datapath #(
    .ANGLE_BITS       (ANGLE_BITS),
    .VECTOR_FRAC_BITS (VECTOR_FRAC_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .look_enable_i  (look_enable_i),
    .key_forward_i  (key_forward_i),
    .key_backward_i (key_backward_i),
    .key_left_i     (key_left_i),
    .key_right_i    (key_right_i),
    .mouse_dx_i     (mouse_dx_i),
    .mouse_dy_i     (mouse_dy_i),
    .pos_x_o        (pos_x_o),
    .pos_y_o        (pos_y_o),
    .pos_z_o        (pos_z_o),
    .front_x_o      (front_x_o),
    .front_y_o      (front_y_o),
    .front_z_o      (front_z_o),
    .right_x_o      (right_x_o),
    .right_y_o      (right_y_o),
    .right_z_o      (right_z_o),
    .up_x_o         (up_x_o),
    .up_y_o         (up_y_o),
    .up_z_o         (up_z_o)
  );

endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for fly_camera_orientation_update_top.
// Drives frames through the valid/ready input channel, predicts each result with
// its own fixed-point camera model and compares every field. Depends on fcou_pkg.
`timescale 1ns / 100ps

module testbench;

  localparam int ABITS = 24;
  localparam int VFRAC = 14;
  localparam int LATENCY = 42;

  typedef struct packed {
    logic look, fwd, bwd, lft, rgt;
    logic signed [15:0] dx, dy;
  } frame_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
    logic signed [15:0] fx, fy, fz, rx, ry, rz, ux, uy, uz;
  } camera_t;

  typedef struct {
    frame_t  frm;
    logic    has_exp;
    camera_t exp;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [fcou_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [fcou_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  frame_t frm_drv = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  camera_t cam_out;

  fly_camera_orientation_update_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid_i, .in_ready_o,
    .look_enable_i(frm_drv.look), .key_forward_i(frm_drv.fwd),
    .key_backward_i(frm_drv.bwd), .key_left_i(frm_drv.lft),
    .key_right_i(frm_drv.rgt), .mouse_dx_i(frm_drv.dx), .mouse_dy_i(frm_drv.dy),
    .out_valid_o, .out_ready_i,
    .pos_x_o(cam_out.px), .pos_y_o(cam_out.py), .pos_z_o(cam_out.pz),
    .front_x_o(cam_out.fx), .front_y_o(cam_out.fy), .front_z_o(cam_out.fz),
    .right_x_o(cam_out.rx), .right_y_o(cam_out.ry), .right_z_o(cam_out.rz),
    .up_x_o(cam_out.ux), .up_y_o(cam_out.uy), .up_z_o(cam_out.uz)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  initial begin
    #50ms;
    $display("testbench: errors");
    $finish;
  end

  // Camera model state
  longint speed, gain, plimit;
  longint cam_px, cam_py, cam_pz, pitch;
  longint unsigned yaw;
  longint fvec[3], rvec[3];

  camera_t expected_frames[$];
  int n_err = 0, n_frames = 0, n_checked = 0;

  function automatic longint fl_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    if (s == 0) return v;
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clampl(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Sine and cosine of a 2^-32 turn angle, Q30
  task automatic sincos(input logic [31:0] a, output longint c, output longint s);
    longint z, x, y, nx;
    logic flip;
    longint atan_tab[30] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
      41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5, 3, 1};
    z = longint'(signed'(a));
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (z > 1073741824) begin
      z -= 64'sd2147483648; flip = 1'b1;
    end else if (z < -1073741824) begin
      z += 64'sd2147483648; flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      if (z >= 0) begin
        nx = x - fl_shift(y, i); y = y + fl_shift(x, i); z -= atan_tab[i];
      end else begin
        nx = x + fl_shift(y, i); y = y - fl_shift(x, i); z += atan_tab[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endtask

  function automatic longint vec30(longint v);
    return clampl(rnd_shift(v, 30 - VFRAC), -(64'sd1 << VFRAC), 64'sd1 << VFRAC);
  endfunction

  function automatic longint vec60(longint v);
    return clampl(rnd_shift(v, 60 - VFRAC), -(64'sd1 << VFRAC), 64'sd1 << VFRAC);
  endfunction

  task automatic camera_reset();
    speed = fcou_pkg::MOVE_SPEED_RST;
    gain = fcou_pkg::LOOK_GAIN_RST;
    plimit = fcou_pkg::PITCH_LIMIT_RST;
    cam_px = 0; cam_py = 458752; cam_pz = 1310720;
    yaw = (64'd1 << ABITS) - (64'd1 << (ABITS - 2));
    pitch = 0;
    fvec = '{0, 0, -(64'sd1 << VFRAC)};
    rvec = '{64'sd1 << VFRAC, 0, 0};
  endtask

  task automatic camera_step(input frame_t f, output camera_t r);
    longint quarter, lim, fw, rt, d[3], cy, sy, cp, sp;
    logic [31:0] a;
    quarter = 64'sd1 << (ABITS - 2);
    lim = plimit > quarter ? quarter : plimit;
    if (f.look) begin
      fw = longint'(f.fwd) - longint'(f.bwd);
      rt = longint'(f.rgt) - longint'(f.lft);
      for (int k = 0; k < 3; k++)
        d[k] = rnd_shift((fw * fvec[k] + rt * rvec[k]) * speed, VFRAC);
      cam_px = clampl(cam_px + d[0], -64'sd2147483648, 64'sd2147483647);
      cam_py = clampl(cam_py + d[1], -64'sd2147483648, 64'sd2147483647);
      cam_pz = clampl(cam_pz + d[2], -64'sd2147483648, 64'sd2147483647);
      yaw = (yaw + longint'(f.dx) * gain) & ((64'd1 << ABITS) - 1);
      pitch = pitch + longint'(f.dy) * gain;
    end
    pitch = clampl(pitch, -lim, lim);
    a = 32'(yaw << (32 - ABITS));
    sincos(a, cy, sy);
    a = 32'((pitch & ((64'sd1 << ABITS) - 1)) << (32 - ABITS));
    sincos(a, cp, sp);
    fvec = '{vec60(cy * cp), vec30(sp), vec60(sy * cp)};
    rvec = '{vec30(-sy), 0, vec30(cy)};
    r.px = 32'(cam_px); r.py = 32'(cam_py); r.pz = 32'(cam_pz);
    r.fx = 16'(fvec[0]); r.fy = 16'(fvec[1]); r.fz = 16'(fvec[2]);
    r.rx = 16'(rvec[0]); r.ry = 16'(rvec[1]); r.rz = 16'(rvec[2]);
    r.ux = 16'(vec60(-(cy * sp))); r.uy = 16'(vec30(cp)); r.uz = 16'(vec60(-(sy * sp)));
  endtask

  task automatic report(input string what, input camera_t e, input camera_t a);
    n_err++;
    if (n_err <= 10)
      $display("%0t %s: exp %p got %p", $time, what, e, a);
  endtask

  // Result side: random stall, check each transfer against the oldest expectation
  initial begin
    camera_t e;
    int gap;
    @(posedge rst_ni);
    forever begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (gap != 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      if (expected_frames.size() == 0) begin
        report("unexpected result", '0, cam_out);
      end else begin
        e = expected_frames.pop_front();
        n_checked++;
        if (e !== cam_out) report("mismatch", e, cam_out);
      end
      @(negedge clk_i);
    end
  end

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_frames.size() != 0) @(negedge clk_i);
    repeat (LATENCY + 8) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [fcou_pkg::CFG_IDX_W-1:0] idx, input longint v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= fcou_pkg::CFG_DATA_W'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == fcou_pkg::CFG_MOVE_SPEED) speed = v & 16'hFFFF;
    else if (idx == fcou_pkg::CFG_LOOK_GAIN) gain = v & 16'hFFFF;
    else if (idx == fcou_pkg::CFG_PITCH_LIMIT) plimit = v & 23'h7FFFFF;
    @(negedge clk_i);
  endtask

  // Send one frame; optionally hold a typed-in expectation against the model's
  task automatic send_frame(input frame_t f, input logic has_exp, input camera_t want);
    camera_t p;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    camera_step(f, p);
    if (has_exp && p !== want) report("typed expectation", want, p);
    expected_frames.push_back(p);
    frm_drv <= f;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    n_frames++;
  endtask

  function automatic frame_t rand_frame();
    frame_t f;
    f = frame_t'({$urandom, $urandom});
    f.look = ($urandom_range(0, 7) != 0);
    case ($urandom_range(0, 3))
      0: f.dx = 16'($signed($urandom_range(0, 40)) - 20);
      1: f.dy = 16'($signed($urandom_range(0, 40)) - 20);
      default: ;
    endcase
    return f;
  endfunction

  row_t dir_rows[$];

  initial begin
    camera_t z0, z1;
    camera_reset();
    // Frame after reset with look off: pitch zero, yaw minus a quarter turn
    z0 = '{px: 0, py: 458752, pz: 1310720, fx: 0, fy: 0, fz: -16384,
           rx: 16384, ry: 0, rz: 0, ux: 0, uy: 16384, uz: 0};
    z1 = '0;
    dir_rows.push_back('{'{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 16'sh7FFF, 16'sh7FFF}, 1'b1, z0});
    dir_rows.push_back('{'{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'sd0, 16'sd0}, 1'b0, z1});
    dir_rows.push_back('{'{1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 16'sd0, 16'sd0}, 1'b0, z1});
    dir_rows.push_back('{'{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 16'sd0, 16'sd0}, 1'b0, z1});
    dir_rows.push_back('{'{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 16'sd0, 16'sd0}, 1'b0, z1});
    // opposing keys cancel
    dir_rows.push_back('{'{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 16'sd0, 16'sd0}, 1'b0, z1});
    // pitch clamp both ways, yaw wrap at extreme deltas
    dir_rows.push_back('{'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh7FFF, 16'sh7FFF}, 1'b0, z1});
    dir_rows.push_back('{'{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 16'sh8000, 16'sh8000}, 1'b0, z1});
    dir_rows.push_back('{'{1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 16'sd1, -16'sd1}, 1'b0, z1});
    dir_rows.push_back('{'{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, -16'sd1, 16'sd1}, 1'b0, z1});
    dir_rows.push_back('{'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'sh5555, 16'shAAAA}, 1'b0, z1});
    dir_rows.push_back('{'{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 16'shAAAA, 16'sh5555}, 1'b0, z1});

    cfg_we_i = 1'b0;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send_frame(dir_rows[i].frm, dir_rows[i].has_exp, dir_rows[i].exp);
    wait_idle();

    // Extremes: top speed and gain, pitch limit above a quarter turn, then all zero
    write_reg(fcou_pkg::CFG_MOVE_SPEED, 65535);
    write_reg(fcou_pkg::CFG_LOOK_GAIN, 65535);
    write_reg(fcou_pkg::CFG_PITCH_LIMIT, 23'h7FFFFF);
    // full speed forward and right with pitch up, many frames
    repeat (20) send_frame('{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 16'sd0, 16'sh7FFF}, 1'b0, z1);
    for (int i = 0; i < 8; i++) send_frame(rand_frame(), 1'b0, z1);
    wait_idle();
    write_reg(fcou_pkg::CFG_PITCH_LIMIT, 0);
    write_reg(fcou_pkg::CFG_MOVE_SPEED, 0);
    write_reg(fcou_pkg::CFG_LOOK_GAIN, 0);
    for (int i = 0; i < 8; i++) send_frame(rand_frame(), 1'b0, z1);
    wait_idle();

    // Random phases over several settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(fcou_pkg::CFG_MOVE_SPEED, $urandom_range(0, 65535));
      write_reg(fcou_pkg::CFG_LOOK_GAIN, $urandom_range(0, 65535));
      write_reg(fcou_pkg::CFG_PITCH_LIMIT, ph == 4 ? 4194304 : $urandom_range(0, 23'h7FFFFF));
      // unused index must be ignored
      write_reg(2'd3, $urandom);
      for (int i = 0; i < 100; i++) send_frame(rand_frame(), 1'b0, z1);
      wait_idle();
    end

    $display("Sent %0d frames, checked %0d results across eight register settings.",
             n_frames, n_checked);
    $display("%0d mismatches in total.", n_err);
    if (n_err == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
